FILE: rtl/assert_macros.svh
// assertion helpers included by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define VTLL_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked in every cycle, reset included
`define VTLL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/vtll_pkg.sv
// ----------------------------------------------------------------------------
// vtll_pkg
// Types and constants of the vertex transform and lambert lighting block.
// ----------------------------------------------------------------------------
package vtll_pkg;

    // result bits of the normalizing search (k = floor(2 * scaled length))
    localparam int NORM_BITS = 16;

    // configuration register indexes
    localparam logic [2:0] CFG_ROW0   = 3'd0;
    localparam logic [2:0] CFG_ROW1   = 3'd1;
    localparam logic [2:0] CFG_ROW2   = 3'd2;
    localparam logic [2:0] CFG_ROW3   = 3'd3;
    localparam logic [2:0] CFG_LDIR   = 3'd4;
    localparam logic [2:0] CFG_LCOL   = 3'd5;
    localparam logic [2:0] CFG_SMOOTH = 3'd6;

    typedef struct packed {
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] pos_z;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
    } t_vtx_in;

    typedef struct packed {
        logic signed [31:0] clip_x;
        logic signed [31:0] clip_y;
        logic signed [31:0] clip_z;
        logic signed [31:0] clip_w;
        logic signed [15:0] out_norm_x;
        logic signed [15:0] out_norm_y;
        logic signed [15:0] out_norm_z;
        logic        [15:0] color_r;
        logic        [15:0] color_g;
        logic        [15:0] color_b;
    } t_vtx_out;

endpackage

FILE: rtl/vtll_norm_lane.sv
// ----------------------------------------------------------------------------
// vtll_norm_lane
// Pipelined normalization of one normal component: one result bit per stage,
// gives round(|n| * 16384 / sqrt(s)) with halves rounded up.
// ----------------------------------------------------------------------------
module vtll_norm_lane (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic signed [15:0]               i_n,
    input  logic        [31:0]               i_s,
    output logic [vtll_pkg::NORM_BITS-2:0]   o_m
);
    localparam int NB = vtll_pkg::NORM_BITS;

    logic [63:0]   r_rem [0:NB];
    logic [47:0]   r_ks  [0:NB];
    logic [NB-1:0] r_k   [0:NB];
    logic [31:0]   r_s   [0:NB];
    logic          r_z   [0:NB];

    logic [63:0]   n_rem [0:NB];
    logic [47:0]   n_ks  [0:NB];
    logic [NB-1:0] n_k   [0:NB];
    logic [31:0]   n_s   [0:NB];
    logic          n_z   [0:NB];

    logic [65:0]   n_trial [0:NB];
    logic [15:0]   n_mag;

    // rem = |n|^2 * 2^30 - k^2 * s, ks = k * s
    always_comb begin
        n_mag      = i_n[15] ? 16'(-i_n) : 16'(i_n);
        n_rem[0]   = {2'b00, 32'(n_mag * n_mag), 30'd0};
        n_ks[0]    = '0;
        n_k[0]     = '0;
        n_s[0]     = i_s;
        n_z[0]     = (n_mag == 16'd0);
        n_trial[0] = '0;
        for (int j = 1; j <= NB; j++) begin
            n_trial[j] = ({18'd0, r_ks[j-1]} << (NB - j + 1))
                       + ({34'd0, r_s[j-1]} << (2 * (NB - j)));
            n_s[j] = r_s[j-1];
            n_z[j] = r_z[j-1];
            if ({2'b00, r_rem[j-1]} >= n_trial[j]) begin
                n_rem[j] = r_rem[j-1] - n_trial[j][63:0];
                n_ks[j]  = r_ks[j-1] + ({16'd0, r_s[j-1]} << (NB - j));
                n_k[j]   = r_k[j-1] | (NB'(1) << (NB - j));
            end else begin
                n_rem[j] = r_rem[j-1];
                n_ks[j]  = r_ks[j-1];
                n_k[j]   = r_k[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j <= NB; j++) begin
                r_rem[j] <= n_rem[j];
                r_ks[j]  <= n_ks[j];
                r_k[j]   <= n_k[j];
                r_s[j]   <= n_s[j];
                r_z[j]   <= n_z[j];
            end
        end
    end

    // largest m with 2m-1 <= k
    assign o_m = r_z[NB] ? '0 : (NB-1)'(({1'b0, r_k[NB]} + (NB+1)'(1)) >> 1);

endmodule

FILE: rtl/vertex_transform_lambert_light_top.sv
// ----------------------------------------------------------------------------
// vertex_transform_lambert_light_top
// Vertex transform to clip space with per-vertex lambert lighting.
// ----------------------------------------------------------------------------
// Takes one vertex word per cycle and returns one result word per vertex;
// throughput is one word per clock as long as the output is not stalled. The
// latency is set by the normalizing search, which settles one bit of each normal
// component per pipeline stage (17 stages). A stall on a valid output word
// freezes the whole pipeline. Configuration registers may be written only while
// the pipeline is empty.
module vertex_transform_lambert_light_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  vtll_pkg::t_vtx_in    i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output vtll_pkg::t_vtx_out   o_data,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_idx,
    input  logic [63:0]          i_cfg_data
);
    `include "assert_macros.svh"

    localparam int LANE_LAT = vtll_pkg::NORM_BITS + 1;
    localparam int NSTG     = 25;
    localparam int CLIP_DLY = NSTG - 3;

    // configuration
    logic [63:0] r_mat [0:3];
    logic [47:0] r_ldir;
    logic [47:0] r_lcol;
    logic        r_smooth;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mat[0] <= 64'h0000_0000_0000_0100;
            r_mat[1] <= 64'h0000_0000_0100_0000;
            r_mat[2] <= 64'h0000_0100_0000_0000;
            r_mat[3] <= 64'h0100_0000_0000_0000;
            r_ldir   <= '0;
            r_lcol   <= 48'h0100_0100_0100;
            r_smooth <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                vtll_pkg::CFG_ROW0:   r_mat[0] <= i_cfg_data;
                vtll_pkg::CFG_ROW1:   r_mat[1] <= i_cfg_data;
                vtll_pkg::CFG_ROW2:   r_mat[2] <= i_cfg_data;
                vtll_pkg::CFG_ROW3:   r_mat[3] <= i_cfg_data;
                vtll_pkg::CFG_LDIR:   r_ldir   <= i_cfg_data[47:0];
                vtll_pkg::CFG_LCOL:   r_lcol   <= i_cfg_data[47:0];
                vtll_pkg::CFG_SMOOTH: r_smooth <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // pipeline control
    logic [NSTG-1:0] r_vld;
    logic            w_en;

    assign w_en    = !(r_vld[NSTG-1] && i_stall);
    assign o_stall = !i_rst_n || !w_en;
    assign o_valid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
        end
    end

    // payload registers, stage by stage
    logic signed [23:0] r_pos   [0:2];
    logic signed [15:0] r_n_a   [0:2];
    logic signed [39:0] r_prod  [0:3][0:3];
    logic        [31:0] r_sq    [0:2];
    logic signed [15:0] r_n_b   [0:2];
    logic signed [41:0] r_sum   [0:3];
    logic        [31:0] r_s;
    logic signed [15:0] r_n_c   [0:2];
    logic signed [31:0] r_clip  [0:CLIP_DLY-1][0:3];
    logic signed [15:0] r_nd    [0:LANE_LAT-1][0:2];
    logic signed [15:0] r_on    [0:4][0:2];
    logic signed [31:0] r_dp    [0:2];
    logic        [31:0] r_inten;
    logic        [47:0] r_cp    [0:2];
    logic        [15:0] r_col   [0:2];

    logic signed [39:0] n_prod  [0:3][0:3];
    logic signed [41:0] n_sum   [0:3];
    logic signed [31:0] n_clip  [0:3];
    logic signed [41:0] n_rnd   [0:3];
    logic signed [33:0] n_q     [0:3];
    logic signed [15:0] n_on    [0:2];
    logic signed [33:0] n_dsum;
    logic [vtll_pkg::NORM_BITS-2:0] w_m [0:2];
    logic        [19:0] n_cv    [0:2];

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 3; c++) begin
                n_prod[r][c] = 40'($signed(r_mat[r][16*c +: 16])) * 40'(r_pos[c]);
            end
            // w term: times 1.0
            n_prod[r][3] = 40'($signed(r_mat[r][63:48])) <<< 8;
            n_sum[r] = 42'(r_prod[r][0]) + 42'(r_prod[r][1])
                     + 42'(r_prod[r][2]) + 42'(r_prod[r][3]);
            n_rnd[r] = r_sum[r] + 42'sd128;
            n_q[r]   = 34'(n_rnd[r] >>> 8);
            if (n_q[r] > 34'sh0_7FFF_FFFF) begin
                n_clip[r] = 32'sh7FFF_FFFF;
            end else if (n_q[r] < -34'sh0_8000_0000) begin
                n_clip[r] = 32'sh8000_0000;
            end else begin
                n_clip[r] = 32'(n_q[r]);
            end
        end
        for (int i = 0; i < 3; i++) begin
            if (r_smooth) begin
                n_on[i] = r_nd[LANE_LAT-1][i][15] ? -16'(w_m[i]) : 16'(w_m[i]);
            end else begin
                n_on[i] = r_nd[LANE_LAT-1][i];
            end
        end
        n_dsum = -(34'(r_dp[0]) + 34'(r_dp[1]) + 34'(r_dp[2]));
        for (int i = 0; i < 3; i++) begin
            n_cv[i] = 20'((r_cp[i] + 48'd134217728) >> 28);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pos[0] <= i_data.pos_x;
            r_pos[1] <= i_data.pos_y;
            r_pos[2] <= i_data.pos_z;
            r_n_a[0] <= i_data.norm_x;
            r_n_a[1] <= i_data.norm_y;
            r_n_a[2] <= i_data.norm_z;

            r_prod <= n_prod;
            for (int i = 0; i < 3; i++) begin
                r_sq[i]  <= 32'(r_n_a[i] * r_n_a[i]);
                r_n_b[i] <= r_n_a[i];
                r_n_c[i] <= r_n_b[i];
            end

            r_sum <= n_sum;
            r_s   <= r_sq[0] + r_sq[1] + r_sq[2];

            r_clip[0] <= n_clip;
            for (int k = 1; k < CLIP_DLY; k++) begin
                r_clip[k] <= r_clip[k-1];
            end
            r_nd[0] <= r_n_c;
            for (int k = 1; k < LANE_LAT; k++) begin
                r_nd[k] <= r_nd[k-1];
            end

            r_on[0] <= n_on;
            for (int k = 1; k < 5; k++) begin
                r_on[k] <= r_on[k-1];
            end
            for (int i = 0; i < 3; i++) begin
                r_dp[i] <= $signed(r_ldir[16*i +: 16]) * r_on[0][i];
            end
            r_inten <= (n_dsum > 34'sd0) ? 32'(n_dsum) : 32'd0;
            for (int i = 0; i < 3; i++) begin
                r_cp[i]  <= 48'(r_lcol[16*i +: 16]) * 48'(r_inten);
                r_col[i] <= (n_cv[i] > 20'hFFFF) ? 16'hFFFF : n_cv[i][15:0];
            end
        end
    end

    // one normalizing search per component
    for (genvar g = 0; g < 3; g++) begin : g_lane
        vtll_norm_lane u_lane (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_n   (r_n_c[g]),
            .i_s   (r_s),
            .o_m   (w_m[g])
        );
    end

    assign o_data.clip_x     = r_clip[CLIP_DLY-1][0];
    assign o_data.clip_y     = r_clip[CLIP_DLY-1][1];
    assign o_data.clip_z     = r_clip[CLIP_DLY-1][2];
    assign o_data.clip_w     = r_clip[CLIP_DLY-1][3];
    assign o_data.out_norm_x = r_on[4][0];
    assign o_data.out_norm_y = r_on[4][1];
    assign o_data.out_norm_z = r_on[4][2];
    assign o_data.color_r    = r_col[0];
    assign o_data.color_g    = r_col[1];
    assign o_data.color_b    = r_col[2];

    // a zero output normal can never light the vertex
    `VTLL_ASSERT(a_zero_norm_dark, i_clk, i_rst_n,
        (o_valid && o_data.out_norm_x == 16'sd0 && o_data.out_norm_y == 16'sd0
            && o_data.out_norm_z == 16'sd0) |-> (o_data.color_r == 16'd0
            && o_data.color_g == 16'd0 && o_data.color_b == 16'd0),
        "lit color from zero normal")
    `VTLL_ASSERT(a_accept_enters, i_clk, i_rst_n,
        (i_valid && !o_stall) |=> r_vld[0], "accepted word not in first stage")
    `VTLL_ASSERT_ALWAYS(a_reset_empty, i_clk,
        (!i_rst_n) |=> !o_valid, "output valid after reset")

endmodule

FILE: tb/vtll_checker.sv
// ----------------------------------------------------------------------------
// vtll_checker
// Watches the vertex and result channels and the register port, predicts each
// result word from its own copy of the registers and compares field by field.
// ----------------------------------------------------------------------------
module vtll_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  vtll_pkg::t_vtx_in    i_in_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  vtll_pkg::t_vtx_out   i_out_data,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_idx,
    input  logic [63:0]          i_cfg_data,
    output int                   o_pending,
    output int                   o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef longint t_fields [10];

    logic [63:0]        mat_row [4];
    logic [47:0]        lamp_vec;
    logic [47:0]        light_col;
    logic               smooth;
    vtll_pkg::t_vtx_out vtx_expected [$];
    string       field_names [10] = '{"clip_x", "clip_y", "clip_z", "clip_w", "out_norm_x",
                                      "out_norm_y", "out_norm_z", "color_r", "color_g",
                                      "color_b"};

    // exact round of n * 16384 / sqrt(s), halves away from zero
    function automatic longint unit_comp(longint n, longint unsigned s);
        longint unsigned mag;
        longint unsigned rhs;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned t;
        mag = (n < 0) ? -n : n;
        rhs = (mag * mag) << 30;
        lo = 0;
        hi = 16384;
        if (mag == 0) return 0;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            t = 2 * mid - 1;
            if (t * t * s <= rhs) lo = mid;
            else hi = mid - 1;
        end
        return (n < 0) ? -longint'(lo) : longint'(lo);
    endfunction

    function automatic vtll_pkg::t_vtx_out shade_vertex(vtll_pkg::t_vtx_in v);
        vtll_pkg::t_vtx_out r;
        longint         p [4];
        longint         n [3];
        longint         on [3];
        longint         acc;
        longint         dot;
        longint unsigned s;
        longint unsigned inten;
        longint unsigned c;
        longint unsigned lit;
        longint         clip [4];
        longint unsigned col [3];
        p[0] = longint'(v.pos_x);
        p[1] = longint'(v.pos_y);
        p[2] = longint'(v.pos_z);
        p[3] = 256;
        n[0] = longint'(v.norm_x);
        n[1] = longint'(v.norm_y);
        n[2] = longint'(v.norm_z);
        for (int row = 0; row < 4; row++) begin
            acc = 0;
            for (int j = 0; j < 4; j++)
                acc += longint'($signed(mat_row[row][16*j +: 16])) * p[j];
            acc = (acc + 128) >>> 8;
            if (acc > 64'sd2147483647) acc = 64'sd2147483647;
            if (acc < -64'sd2147483648) acc = -64'sd2147483648;
            clip[row] = acc;
        end
        s = n[0] * n[0] + n[1] * n[1] + n[2] * n[2];
        for (int i = 0; i < 3; i++)
            on[i] = smooth ? ((s == 0) ? 0 : unit_comp(n[i], s)) : n[i];
        dot = 0;
        for (int i = 0; i < 3; i++)
            dot -= longint'($signed(lamp_vec[16*i +: 16])) * on[i];
        inten = (dot > 0) ? dot : 0;
        for (int i = 0; i < 3; i++) begin
            c = light_col[16*i +: 16];
            lit = (c * inten + (64'd1 << 27)) >> 28;
            col[i] = (lit > 16'hFFFF) ? 16'hFFFF : lit;
        end
        r.clip_x = 32'(clip[0]);
        r.clip_y = 32'(clip[1]);
        r.clip_z = 32'(clip[2]);
        r.clip_w = 32'(clip[3]);
        r.out_norm_x = 16'(on[0]);
        r.out_norm_y = 16'(on[1]);
        r.out_norm_z = 16'(on[2]);
        r.color_r = 16'(col[0]);
        r.color_g = 16'(col[1]);
        r.color_b = 16'(col[2]);
        return r;
    endfunction

    function automatic t_fields split_word(vtll_pkg::t_vtx_out w);
        t_fields f;
        f = '{w.clip_x, w.clip_y, w.clip_z, w.clip_w, w.out_norm_x, w.out_norm_y,
              w.out_norm_z, w.color_r, w.color_g, w.color_b};
        return f;
    endfunction

    always @(posedge i_clk) begin
        t_fields want;
        t_fields got;
        if (!i_rst_n) begin
            mat_row[0] = 64'd256;
            mat_row[1] = 64'd256 << 16;
            mat_row[2] = 64'd256 << 32;
            mat_row[3] = 64'd256 << 48;
            lamp_vec = '0;
            light_col = 48'h0100_0100_0100;
            smooth = 1'b1;
            vtx_expected.delete();
            o_errors = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    vtll_pkg::CFG_ROW0:   mat_row[0] = i_cfg_data;
                    vtll_pkg::CFG_ROW1:   mat_row[1] = i_cfg_data;
                    vtll_pkg::CFG_ROW2:   mat_row[2] = i_cfg_data;
                    vtll_pkg::CFG_ROW3:   mat_row[3] = i_cfg_data;
                    vtll_pkg::CFG_LDIR:   lamp_vec = i_cfg_data[47:0];
                    vtll_pkg::CFG_LCOL:   light_col = i_cfg_data[47:0];
                    vtll_pkg::CFG_SMOOTH: smooth = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                vtx_expected.push_back(shade_vertex(i_in_data));
            if (i_out_valid && !i_out_stall) begin
                if (vtx_expected.size() == 0) begin
                    $display("%0t: result word with nothing expected: %h", $time, i_out_data);
                    o_errors++;
                end else begin
                    want = split_word(vtx_expected.pop_front());
                    got = split_word(i_out_data);
                    for (int i = 0; i < 10; i++)
                        if (want[i] != got[i]) begin
                            $display("%0t: %s expected %0d actual %0d", $time,
                                     field_names[i], want[i], got[i]);
                            o_errors++;
                        end
                end
            end
        end
        o_pending = vtx_expected.size();
    end

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives vertices and register writes into the vertex lighting block under
// random idle and stall, while the checker predicts and compares each result.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    vtll_pkg::t_vtx_in  i_data;
    logic               o_valid;
    logic               i_stall;
    vtll_pkg::t_vtx_out o_data;
    logic               i_cfg_we;
    logic [2:0]         i_cfg_idx;
    logic [63:0]        i_cfg_data;
    int                 pending;
    int                 errors;
    int                 tx_idle_pct;
    int                 rx_stall_pct;
    int                 vertex_count;

    vertex_transform_lambert_light_top u_top (.*);

    vtll_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_stall  (o_stall),
        .i_in_data   (i_data),
        .i_out_valid (o_valid),
        .i_out_stall (i_stall),
        .i_out_data  (o_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < rx_stall_pct);
    end

    initial begin
        #10ms;
        $display("Verification failed");
        $finish;
    end

    task automatic send_vertex(vtll_pkg::t_vtx_in v);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < tx_idle_pct) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= v;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        vertex_count++;
    endtask

    // hold the vertex side until the pipeline is empty and settled
    task automatic drain;
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
    endtask

    task automatic load_regs(logic [63:0] r0, logic [63:0] r1, logic [63:0] r2,
                             logic [63:0] r3, logic [63:0] ldir, logic [63:0] lcol,
                             logic [63:0] smooth);
        write_reg(vtll_pkg::CFG_ROW0, r0);
        write_reg(vtll_pkg::CFG_ROW1, r1);
        write_reg(vtll_pkg::CFG_ROW2, r2);
        write_reg(vtll_pkg::CFG_ROW3, r3);
        write_reg(vtll_pkg::CFG_LDIR, ldir);
        write_reg(vtll_pkg::CFG_LCOL, lcol);
        write_reg(vtll_pkg::CFG_SMOOTH, smooth);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [15:0] rand_q14();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'($urandom_range(33000) - 16500);
            2: return 16'($urandom_range(64) - 32);
            default: return 16'h8000 + 16'($urandom_range(3));
        endcase
    endfunction

    function automatic vtll_pkg::t_vtx_in rand_vertex();
        vtll_pkg::t_vtx_in v;
        v.pos_x = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(8192) - 4096);
        v.pos_y = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(8192) - 4096);
        v.pos_z = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(8192) - 4096);
        if ($urandom_range(15) == 0) begin
            v.norm_x = '0;
            v.norm_y = '0;
            v.norm_z = '0;
        end else begin
            v.norm_x = rand_q14();
            v.norm_y = rand_q14();
            v.norm_z = rand_q14();
        end
        return v;
    endfunction

    function automatic vtll_pkg::t_vtx_in make_vertex(
        logic [23:0] x, logic [23:0] y, logic [23:0] z,
        logic [15:0] nx, logic [15:0] ny, logic [15:0] nz);
        vtll_pkg::t_vtx_in v;
        v = {x, y, z, nx, ny, nz};
        return v;
    endfunction

    task automatic directed_set;
        send_vertex(make_vertex(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
        send_vertex(make_vertex(24'h800000, 24'h800000, 24'h800000, 16'h8000, 16'h8000, 16'h8000));
        send_vertex(make_vertex(24'h7FFFFF, 24'h800000, 24'h000000, 16'h0000, 16'h0000, 16'h0000));
        send_vertex(make_vertex(24'h000100, 24'hFFFF00, 24'h000080, 16'h4000, 16'h0000, 16'h0000));
        send_vertex(make_vertex(24'h000000, 24'h000000, 24'h000000, 16'h0000, 16'hC000, 16'h0000));
        send_vertex(make_vertex(24'hFFFFFF, 24'h000001, 24'hFFFF80, 16'h0001, 16'h0001, 16'h0000));
        send_vertex(make_vertex(24'h123456, 24'hABCDEF, 24'h555555, 16'h2000, 16'h2000, 16'hE000));
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        i_stall = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = vtll_pkg::CFG_ROW0;
        i_cfg_data = '0;
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        vertex_count = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset registers: identity transform, no light
        directed_set();
        drain();

        // light head-on, unit color, flat normals
        load_regs(64'h0000_0000_0000_0100, 64'h0000_0000_0100_0000,
                  64'h0000_0100_0000_0000, 64'h0100_0000_0000_0000,
                  64'hFFFF_0000_0000_C000, 64'hFFFF_0100_0100_0100, 64'h0);
        directed_set();
        drain();
        // saturating matrix, oversized light, full color; index past the end is ignored
        load_regs(64'h7FFF_7FFF_7FFF_7FFF, 64'h8000_8000_8000_8000,
                  64'h7FFF_8000_7FFF_8000, 64'h8000_7FFF_0000_0001,
                  64'h0000_8000_8000_8000, 64'h0000_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(vtll_pkg::CFG_SMOOTH + 3'd1, 64'hDEAD_BEEF_0000_0000);
        i_cfg_we <= 1'b0;
        directed_set();
        drain();
        load_regs(64'h0, 64'h0, 64'h0, 64'h0,
                  64'h0000_7FFF_7FFF_7FFF, 64'h0000_0000_0000_0001, 64'h1);
        directed_set();
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            tx_idle_pct = (phase < 2) ? 32 : (phase < 4) ? 64 : 0;
            rx_stall_pct = (phase < 2) ? 64 : (phase < 4) ? 32 : 0;
            load_regs(rand64(), rand64(), rand64(), rand64(),
                      64'({rand_q14(), rand_q14(), rand_q14()}), rand64(),
                      64'($urandom_range(1)));
            for (int k = 0; k < 85; k++) begin
                send_vertex(rand_vertex());
                // stretches without idle gaps
                if (k == 40) tx_idle_pct = 0;
            end
            drain();
        end

        tx_idle_pct = 0;
        rx_stall_pct = 0;
        $display("covered %0d vertices over directed extremes and six random register sets",
                 vertex_count);
        $display("idle and stall mixes swapped between sides, then back to back");
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: vertex_transform_lambert_light_top.f
+incdir+rtl
rtl/vtll_pkg.sv
rtl/vtll_norm_lane.sv
rtl/vertex_transform_lambert_light_top.sv
tb/vtll_checker.sv
tb/tb.sv
